### hw/rtl/phtb_pkg.sv
// Shared types, constants and helpers for the heap term builder.
// Depends on nothing; the cell check and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package phtb_pkg;

  // Sizing of the heap and of the argument register file.
  localparam int HEAP_DEPTH    = 1024;
  localparam int NUM_REGISTERS = 32;

  localparam int ADDR_W = $clog2(HEAP_DEPTH);        // heap address
  localparam int TOP_W  = $clog2(HEAP_DEPTH + 1);    // heap top, holds the depth itself
  localparam int RIDX_W = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;
  localparam int REF_W  = 16;                        // reference / functor name field
  localparam int CMP_W  = (TOP_W > REF_W) ? TOP_W : REF_W;

  // Cell tags.
  localparam logic [1:0] KIND_REF = 2'd0;
  localparam logic [1:0] KIND_STR = 2'd1;
  localparam logic [1:0] KIND_FUN = 2'd2;

  // Commands.
  localparam logic [2:0] CMD_SET_VAR = 3'd0;
  localparam logic [2:0] CMD_SET_VAL = 3'd1;
  localparam logic [2:0] CMD_PUT_STR = 3'd2;
  localparam logic [2:0] CMD_DEREF   = 3'd3;
  localparam logic [2:0] CMD_BIND    = 3'd4;

  // Result status codes.
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FAIL  = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_RANGE = 2'd3;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       arity;
    logic [REF_W-1:0] ref_f;
  } cell_t;

  localparam int CELL_W = $bits(cell_t);

  typedef struct packed {
    logic [2:0]  command;
    logic [4:0]  register_index;
    logic [15:0] functor_name;
    logic [7:0]  functor_arity;
    logic [9:0]  address_a;
    logic [9:0]  address_b;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_address;
    logic [1:0]  cell_kind;
    logic [7:0]  cell_arity;
    logic [15:0] cell_ref;
  } out_item_t;

  // Verdict of the cell compare unit on one heap cell.
  typedef struct packed {
    logic follow;   // REF cell that points elsewhere
    logic unbound;  // REF cell that points at itself
    logic beyond;   // reference at or above the heap top
  } chk_t;

  // Register index reduced modulo the register count by restoring subtraction.
  function automatic logic [RIDX_W-1:0] reg_mod(input logic [4:0] idx);
    logic [12:0] r;
    logic [12:0] d;
    r = {8'd0, idx};
    for (int k = 4; k >= 0; k--) begin
      d = 13'(NUM_REGISTERS) << k;
      if (r >= d) begin
        r = r - d;
      end
    end
    return RIDX_W'(r);
  endfunction

endpackage

### hw/rtl/phtb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package dependencies.
`timescale 1ns / 1ps

module phtb_ram #(
  parameter int WIDTH = 26,
  parameter int DEPTH = 1024
) (
  input  logic                                         clk_i,
  input  logic                                         we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                             wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                             rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### hw/rtl/phtb_cell_check.sv
// Shared compare unit: classifies one heap cell during a reference walk.
// Depends on phtb_pkg for the cell layout and widths.
`timescale 1ns / 1ps

module phtb_cell_check (
  input  phtb_pkg::cell_t                cell_i,
  input  logic [phtb_pkg::ADDR_W-1:0]    addr_i,
  input  logic [phtb_pkg::TOP_W-1:0]     top_i,
  output phtb_pkg::chk_t                 chk_o
);

  logic [phtb_pkg::CMP_W-1:0] ref_ext;
  logic [phtb_pkg::CMP_W-1:0] addr_ext;
  logic [phtb_pkg::CMP_W-1:0] top_ext;
  logic                       is_ref;

  assign ref_ext  = phtb_pkg::CMP_W'(cell_i.ref_f);
  assign addr_ext = phtb_pkg::CMP_W'(addr_i);
  assign top_ext  = phtb_pkg::CMP_W'(top_i);
  assign is_ref   = (cell_i.kind == phtb_pkg::KIND_REF);

  assign chk_o.follow  = is_ref && (ref_ext != addr_ext);
  assign chk_o.unbound = is_ref && (ref_ext == addr_ext);
  assign chk_o.beyond  = (ref_ext >= top_ext);

endmodule

### hw/rtl/prolog_heap_term_builder.sv
// Top level of the heap term builder: command sequencer, heap and register file.
// Depends on phtb_pkg, phtb_ram and phtb_cell_check.
`timescale 1ns / 1ps

// Channel   Direction  Signals                              Payload
// input     in         in_valid_i / in_ready_o              in_data_i  (in_item_t)
// output    out        out_valid_o / out_ready_i            out_data_o (out_item_t)
//
// One command is in flight at a time; in_ready_o is high only while the sequencer idles.
// Every command ends in S_DONE: set_value reads the register before it writes the heap,
// put_structure writes its two cells in turn, deref walks one reference chain and bind walks both.
// The walk follows one link at a time because the single heap read port has a registered
// read, and the next address comes from the data it returns.
// Reset clears heap top and control state only. Heap cells are read only once written;
// registers must be written before being read, which the block does not enforce.
// A finished result waits in the output register; the next command may be accepted
// while it is still waiting, and the sequencer only stalls if a second result is ready.

module prolog_heap_term_builder (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  phtb_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output phtb_pkg::out_item_t  out_data_o
);

  localparam int ADDR_W = phtb_pkg::ADDR_W;
  localparam int TOP_W  = phtb_pkg::TOP_W;
  localparam int CMP_W  = phtb_pkg::CMP_W;
  localparam int REF_W  = phtb_pkg::REF_W;
  localparam int RIDX_W = phtb_pkg::RIDX_W;
  localparam int CELL_W = phtb_pkg::CELL_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SETVAL = 3'd1;
  localparam logic [2:0] S_PUTFUN = 3'd2;
  localparam logic [2:0] S_WALK   = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // Sequencer and walk registers.
  logic [2:0]            state_q, state_d;
  logic [TOP_W-1:0]      top_q, top_d;
  logic                  bind_q, bind_d;
  logic                  side_q, side_d;
  logic [ADDR_W-1:0]     cur_q, cur_d;
  logic [TOP_W-1:0]      steps_q, steps_d;
  logic [ADDR_W-1:0]     b_q, b_d;
  logic [ADDR_W-1:0]     l_q, l_d;
  phtb_pkg::cell_t       cell_l_q, cell_l_d;
  logic                  l_unb_q, l_unb_d;
  logic [15:0]           name_q, name_d;
  logic [7:0]            arity_q, arity_d;
  phtb_pkg::out_item_t   res_q, res_d;
  logic                  out_valid_q, out_valid_d;
  phtb_pkg::out_item_t   out_q, out_d;

  // Memory ports.
  logic                  heap_we;
  logic [ADDR_W-1:0]     heap_waddr;
  phtb_pkg::cell_t       heap_wdata;
  logic [ADDR_W-1:0]     heap_raddr;
  logic [CELL_W-1:0]     heap_rdata_raw;
  phtb_pkg::cell_t       heap_rdata;
  logic                  reg_we;
  logic [RIDX_W-1:0]     reg_waddr;
  phtb_pkg::cell_t       reg_wdata;
  logic [RIDX_W-1:0]     reg_raddr;
  logic [CELL_W-1:0]     reg_rdata_raw;
  phtb_pkg::cell_t       reg_rdata;

  // Helpers.
  logic                  in_fire;
  logic [RIDX_W-1:0]     reg_idx;
  logic [CMP_W-1:0]      top_ext;
  logic [CMP_W-1:0]      a_ext;
  logic [CMP_W-1:0]      b_ext;
  logic [ADDR_W-1:0]     a_addr;
  logic [ADDR_W-1:0]     b_addr;
  logic [ADDR_W-1:0]     top_addr;
  logic [ADDR_W-1:0]     top_addr_p1;
  logic                  full_one;
  logic                  full_two;
  phtb_pkg::chk_t        chk;
  phtb_pkg::cell_t       zero_cell;
  logic [ADDR_W-1:0]     ref_addr;

  assign heap_rdata = phtb_pkg::cell_t'(heap_rdata_raw);
  assign reg_rdata  = phtb_pkg::cell_t'(reg_rdata_raw);

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign reg_idx     = phtb_pkg::reg_mod(in_data_i.register_index);
  assign top_ext     = CMP_W'(top_q);
  assign a_ext       = CMP_W'(in_data_i.address_a);
  assign b_ext       = CMP_W'(in_data_i.address_b);
  assign a_addr      = ADDR_W'(a_ext);
  assign b_addr      = ADDR_W'(b_ext);
  assign top_addr    = ADDR_W'(top_q);
  assign top_addr_p1 = ADDR_W'(top_ext + CMP_W'(1));
  // The heap is full for one cell when the top reached the depth, for two cells
  // when fewer than two remain.
  assign full_one    = (top_ext >= CMP_W'(phtb_pkg::HEAP_DEPTH));
  assign full_two    = ((top_ext + CMP_W'(2)) > CMP_W'(phtb_pkg::HEAP_DEPTH));
  assign zero_cell   = '0;
  assign ref_addr    = ADDR_W'(heap_rdata.ref_f);

  phtb_ram #(
    .WIDTH (CELL_W),
    .DEPTH (phtb_pkg::HEAP_DEPTH)
  ) u_heap (
    .clk_i   (clk_i),
    .we_i    (heap_we),
    .waddr_i (heap_waddr),
    .wdata_i (heap_wdata),
    .raddr_i (heap_raddr),
    .rdata_o (heap_rdata_raw)
  );

  phtb_ram #(
    .WIDTH (CELL_W),
    .DEPTH (phtb_pkg::NUM_REGISTERS)
  ) u_regs (
    .clk_i   (clk_i),
    .we_i    (reg_we),
    .waddr_i (reg_waddr),
    .wdata_i (reg_wdata),
    .raddr_i (reg_raddr),
    .rdata_o (reg_rdata_raw)
  );

  // The one compare unit, shared by every step of both walks of a command.
  phtb_cell_check u_check (
    .cell_i (heap_rdata),
    .addr_i (cur_q),
    .top_i  (top_q),
    .chk_o  (chk)
  );

  always_comb begin
    state_d     = state_q;
    top_d       = top_q;
    bind_d      = bind_q;
    side_d      = side_q;
    cur_d       = cur_q;
    steps_d     = steps_q;
    b_d         = b_q;
    l_d         = l_q;
    cell_l_d    = cell_l_q;
    l_unb_d     = l_unb_q;
    name_d      = name_q;
    arity_d     = arity_q;
    res_d       = res_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    heap_we     = 1'b0;
    heap_waddr  = top_addr;
    heap_wdata  = zero_cell;
    heap_raddr  = cur_q;
    reg_we      = 1'b0;
    reg_waddr   = reg_idx;
    reg_wdata   = zero_cell;
    reg_raddr   = reg_idx;

    // The output register drains independently of the sequencer.
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = S_DONE;
          res_d   = '0;
          name_d  = in_data_i.functor_name;
          arity_d = in_data_i.functor_arity;
          unique case (in_data_i.command)
            phtb_pkg::CMD_SET_VAR: begin
              res_d.result_address = 10'(top_ext);
              if (full_one) begin
                res_d.status = phtb_pkg::STATUS_FULL;
              end else begin
                heap_we          = 1'b1;
                heap_wdata.kind  = phtb_pkg::KIND_REF;
                heap_wdata.arity = '0;
                heap_wdata.ref_f = REF_W'(top_ext);
                reg_we           = 1'b1;
                reg_wdata        = heap_wdata;
                top_d            = TOP_W'(top_ext + CMP_W'(1));
                res_d.cell_kind  = heap_wdata.kind;
                res_d.cell_ref   = heap_wdata.ref_f;
              end
            end
            phtb_pkg::CMD_SET_VAL: begin
              res_d.result_address = 10'(top_ext);
              if (full_one) begin
                res_d.status = phtb_pkg::STATUS_FULL;
              end else begin
                state_d = S_SETVAL;
              end
            end
            phtb_pkg::CMD_PUT_STR: begin
              res_d.result_address = 10'(top_ext);
              if (full_two) begin
                res_d.status = phtb_pkg::STATUS_FULL;
              end else begin
                heap_we          = 1'b1;
                heap_wdata.kind  = phtb_pkg::KIND_STR;
                heap_wdata.arity = '0;
                heap_wdata.ref_f = REF_W'(top_ext + CMP_W'(1));
                reg_we           = 1'b1;
                reg_wdata        = heap_wdata;
                res_d.cell_kind  = heap_wdata.kind;
                res_d.cell_ref   = heap_wdata.ref_f;
                state_d          = S_PUTFUN;
              end
            end
            phtb_pkg::CMD_DEREF, phtb_pkg::CMD_BIND: begin
              if (a_ext >= top_ext) begin
                res_d.status         = phtb_pkg::STATUS_RANGE;
                res_d.result_address = in_data_i.address_a;
              end else if ((in_data_i.command == phtb_pkg::CMD_BIND) &&
                           (b_ext >= top_ext)) begin
                res_d.status         = phtb_pkg::STATUS_RANGE;
                res_d.result_address = in_data_i.address_b;
              end else begin
                heap_raddr = a_addr;
                cur_d      = a_addr;
                b_d        = b_addr;
                steps_d    = '0;
                side_d     = 1'b0;
                bind_d     = (in_data_i.command == phtb_pkg::CMD_BIND);
                state_d    = S_WALK;
              end
            end
            default: begin
              // Unknown commands answer with an all-zero ok result.
            end
          endcase
        end
      end

      S_SETVAL: begin
        // Register data arrived; push it as a new heap cell.
        heap_we          = 1'b1;
        heap_wdata       = reg_rdata;
        top_d            = TOP_W'(top_ext + CMP_W'(1));
        res_d.cell_kind  = reg_rdata.kind;
        res_d.cell_arity = reg_rdata.arity;
        res_d.cell_ref   = reg_rdata.ref_f;
        state_d          = S_DONE;
      end

      S_PUTFUN: begin
        // Second cell of a structure: the functor itself.
        heap_we          = 1'b1;
        heap_waddr       = top_addr_p1;
        heap_wdata.kind  = phtb_pkg::KIND_FUN;
        heap_wdata.arity = arity_q;
        heap_wdata.ref_f = REF_W'(name_q);
        top_d            = TOP_W'(top_ext + CMP_W'(2));
        state_d          = S_DONE;
      end

      S_WALK: begin
        if (chk.follow && (steps_q != TOP_W'(phtb_pkg::HEAP_DEPTH))) begin
          if (chk.beyond) begin
            res_d                = '0;
            res_d.status         = phtb_pkg::STATUS_RANGE;
            res_d.result_address = 10'(CMP_W'(heap_rdata.ref_f));
            state_d              = S_DONE;
          end else begin
            cur_d      = ref_addr;
            heap_raddr = ref_addr;
            steps_d    = steps_q + TOP_W'(1);
          end
        end else if (!bind_q) begin
          res_d.status         = phtb_pkg::STATUS_OK;
          res_d.result_address = 10'(CMP_W'(cur_q));
          res_d.cell_kind      = heap_rdata.kind;
          res_d.cell_arity     = heap_rdata.arity;
          res_d.cell_ref       = heap_rdata.ref_f;
          state_d              = S_DONE;
        end else if (!side_q) begin
          // Left side resolved; start on the right side.
          l_d        = cur_q;
          cell_l_d   = heap_rdata;
          l_unb_d    = chk.unbound;
          side_d     = 1'b1;
          cur_d      = b_q;
          heap_raddr = b_q;
          steps_d    = '0;
        end else begin
          // Both sides resolved: the left side wins if it is unbound.
          state_d          = S_DONE;
          heap_wdata.kind  = phtb_pkg::KIND_REF;
          heap_wdata.arity = '0;
          if (l_unb_q) begin
            heap_we              = 1'b1;
            heap_waddr           = l_q;
            heap_wdata.ref_f     = REF_W'(CMP_W'(cur_q));
            res_d.status         = phtb_pkg::STATUS_OK;
            res_d.result_address = 10'(CMP_W'(l_q));
            res_d.cell_kind      = heap_wdata.kind;
            res_d.cell_arity     = heap_wdata.arity;
            res_d.cell_ref       = heap_wdata.ref_f;
          end else if (chk.unbound) begin
            heap_we              = 1'b1;
            heap_waddr           = cur_q;
            heap_wdata.ref_f     = REF_W'(CMP_W'(l_q));
            res_d.status         = phtb_pkg::STATUS_OK;
            res_d.result_address = 10'(CMP_W'(cur_q));
            res_d.cell_kind      = heap_wdata.kind;
            res_d.cell_arity     = heap_wdata.arity;
            res_d.cell_ref       = heap_wdata.ref_f;
          end else begin
            res_d.status         = phtb_pkg::STATUS_FAIL;
            res_d.result_address = 10'(CMP_W'(l_q));
            res_d.cell_kind      = cell_l_q.kind;
            res_d.cell_arity     = cell_l_q.arity;
            res_d.cell_ref       = cell_l_q.ref_f;
          end
        end
      end

      S_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      top_q       <= '0;
      bind_q      <= 1'b0;
      side_q      <= 1'b0;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      top_q       <= top_d;
      bind_q      <= bind_d;
      side_q      <= side_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q    <= cur_d;
    b_q      <= b_d;
    l_q      <= l_d;
    cell_l_q <= cell_l_d;
    l_unb_q  <= l_unb_d;
    name_q   <= name_d;
    arity_q  <= arity_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

endmodule
